// File: sv/four_level_page_table_walker_unit_defines.svh
// Assertion macros for the page table walker.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define PLTW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PLTW_ASSERT_NEXT(lbl, pre, post, msg) \
  `PLTW_ASSERT(lbl, (pre) |=> (post), msg)
`else
`define PLTW_ASSERT(lbl, prop, msg)
`define PLTW_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// File: sv/pltw_pkg.sv
// Types, codes and address helpers shared by the page table walker.
`default_nettype none

package pltw_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned VaW    = 48;
  localparam int unsigned BytesW = 31;
  localparam int unsigned IdxW   = 9;

  localparam logic ACT_START    = 1'b0;
  localparam logic ACT_RESPONSE = 1'b1;

  localparam logic [1:0] LVL_TOP  = 2'd0;
  localparam logic [1:0] LVL_1G   = 2'd1;
  localparam logic [1:0] LVL_2M   = 2'd2;
  localparam logic [1:0] LVL_LEAF = 2'd3;

  localparam int unsigned PresentBit = 0;
  localparam int unsigned LargeBit   = 7;

  localparam logic [BytesW-1:0] PAGE_1G_BYTES = 31'h4000_0000;
  localparam logic [BytesW-1:0] PAGE_2M_BYTES = 31'h0020_0000;
  localparam logic [BytesW-1:0] PAGE_4K_BYTES = 31'h0000_1000;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_FAULT = 2'd2,
    KIND_STRAY = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    SIZE_4K = 2'd0,
    SIZE_2M = 2'd1,
    SIZE_1G = 2'd2
  } page_size_e;

  typedef struct packed {
    logic             action;
    logic [WordW-1:0] root_table_value;
    logic [VaW-1:0]   vaddr;
    logic [WordW-1:0] entry_word;
  } in_word_t;

  typedef struct packed {
    kind_e             result_kind;
    logic [WordW-1:0]  read_address;
    logic [VaW-1:0]    paddr;
    logic [BytesW-1:0] bytes_left_in_page;
    logic [1:0]        page_size_code;
    logic [1:0]        fault_level;
  } out_word_t;

  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctrl_t;

  function automatic logic [IdxW-1:0] index_at(input logic [1:0] level,
                                               input logic [VaW-1:0] va);
    logic [IdxW-1:0] idx;
    unique case (level)
      LVL_TOP:  idx = va[47:39];
      LVL_1G:   idx = va[38:30];
      LVL_2M:   idx = va[29:21];
      default:  idx = va[20:12];
    endcase
    return idx;
  endfunction

  function automatic logic [WordW-1:0] entry_addr(input logic [WordW-1:0] table_word,
                                                  input logic [1:0] level,
                                                  input logic [VaW-1:0] va);
    return {16'b0, table_word[47:12], index_at(level, va), 3'b000};
  endfunction

endpackage

`default_nettype wire

// File: sv/four_level_page_table_walker_unit.sv
// Top level of the four-level page table walker.
// An accepted word is held in the input register, and its result is written to the
// result register when the word advances; the result is taken from there.
// Throughput: one word per cycle while the result register is not stalled, set by
// the single result pass between the input register and the result register.
// Reset clears both valid flags, the walk state and the read offset.
`default_nettype none
`include "four_level_page_table_walker_unit_defines.svh"

module four_level_page_table_walker_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_write_enable_i,
  input  logic [63:0] cfg_write_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [63:0] root_table_value_i,
  input  logic [47:0] vaddr_i,
  input  logic [63:0] entry_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [63:0] read_address_o,
  output logic [47:0] paddr_o,
  output logic [30:0] bytes_left_in_page_o,
  output logic [1:0]  page_size_code_o,
  output logic [1:0]  fault_level_o
);
  import pltw_pkg::*;

  in_word_t    in_word;
  in_word_t    stage_word;
  stage_ctrl_t ctrl;
  out_word_t   core_result;
  out_word_t   out_result;

  assign in_word.action           = action_i;
  assign in_word.root_table_value = root_table_value_i;
  assign in_word.vaddr            = vaddr_i;
  assign in_word.entry_word       = entry_word_i;

  pltw_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .word_o      (stage_word),
    .ctrl_o      (ctrl)
  );

  pltw_core u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_write_enable_i (cfg_write_enable_i),
    .cfg_write_data_i   (cfg_write_data_i),
    .word_i             (stage_word),
    .ctrl_i             (ctrl),
    .result_o           (core_result)
  );

  pltw_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .result_i    (core_result),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .result_o    (out_result)
  );

  assign result_kind_o        = out_result.result_kind;
  assign read_address_o       = out_result.read_address;
  assign paddr_o              = out_result.paddr;
  assign bytes_left_in_page_o = out_result.bytes_left_in_page;
  assign page_size_code_o     = out_result.page_size_code;
  assign fault_level_o        = out_result.fault_level;

  `PLTW_ASSERT_NEXT(a_advance_fills_out, ctrl.advance, out_valid_o,
                    "advanced word not in result register")
  `PLTW_ASSERT(a_stall_needs_full,
               in_stall_o |-> (ctrl.valid && out_valid_o && out_stall_i),
               "input stalled without a blocked result")
  `PLTW_ASSERT(a_fault_level_only_on_fault,
               (out_valid_o && result_kind_o != KIND_FAULT) |-> (fault_level_o == 2'd0),
               "fault level set outside a fault")
  `PLTW_ASSERT(a_done_fields,
               (out_valid_o && result_kind_o == KIND_DONE) |->
               (bytes_left_in_page_o != 31'd0 && page_size_code_o != 2'd3 &&
                read_address_o == 64'd0),
               "bad translation result")

endmodule

`default_nettype wire

// File: sv/pltw_in_reg.sv
// Input register and stall control of the page table walker.
`default_nettype none

module pltw_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pltw_pkg::in_word_t  in_word_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  output pltw_pkg::in_word_t  word_o,
  output pltw_pkg::stage_ctrl_t ctrl_o
);
  import pltw_pkg::*;

  logic     valid_q;
  in_word_t word_q;
  logic     advance;

  assign advance    = valid_q & (~out_valid_i | ~out_stall_i);
  assign in_stall_o = valid_q & ~advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      word_q <= in_word_i;
    end
  end

  assign word_o         = word_q;
  assign ctrl_o.valid   = valid_q;
  assign ctrl_o.advance = advance;

endmodule

`default_nettype wire

// File: sv/pltw_core.sv
// Walk state, offset register and per-word result logic.
`default_nettype none

module pltw_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_write_enable_i,
  input  logic [63:0]           cfg_write_data_i,
  input  pltw_pkg::in_word_t    word_i,
  input  pltw_pkg::stage_ctrl_t ctrl_i,
  output pltw_pkg::out_word_t   result_o
);
  import pltw_pkg::*;

  logic [WordW-1:0] offset_q;
  logic             busy_q, busy_d;
  logic [1:0]       level_q, level_d;
  logic [VaW-1:0]   va_q, va_d;
  out_word_t        res;

  always_comb begin
    res     = '0;
    busy_d  = busy_q;
    level_d = level_q;
    va_d    = va_q;
    if (word_i.action == ACT_START) begin
      va_d             = word_i.vaddr;
      busy_d           = 1'b1;
      level_d          = LVL_TOP;
      res.result_kind  = KIND_READ;
      res.read_address = entry_addr(word_i.root_table_value, LVL_TOP,
                                    word_i.vaddr) + offset_q;
    end else if (!busy_q) begin
      res.result_kind = KIND_STRAY;
    end else if (!word_i.entry_word[PresentBit]) begin
      res.result_kind = KIND_FAULT;
      res.fault_level = level_q;
      busy_d          = 1'b0;
      level_d         = LVL_TOP;
    end else if (level_q == LVL_1G && word_i.entry_word[LargeBit]) begin
      res.result_kind        = KIND_DONE;
      res.paddr              = {word_i.entry_word[47:30], va_q[29:0]};
      res.bytes_left_in_page = PAGE_1G_BYTES - {1'b0, va_q[29:0]};
      res.page_size_code     = SIZE_1G;
      busy_d                 = 1'b0;
      level_d                = LVL_TOP;
    end else if (level_q == LVL_2M && word_i.entry_word[LargeBit]) begin
      res.result_kind        = KIND_DONE;
      res.paddr              = {word_i.entry_word[47:21], va_q[20:0]};
      res.bytes_left_in_page = PAGE_2M_BYTES - {10'b0, va_q[20:0]};
      res.page_size_code     = SIZE_2M;
      busy_d                 = 1'b0;
      level_d                = LVL_TOP;
    end else if (level_q == LVL_LEAF) begin
      res.result_kind        = KIND_DONE;
      res.paddr              = {word_i.entry_word[47:12], va_q[11:0]};
      res.bytes_left_in_page = PAGE_4K_BYTES - {19'b0, va_q[11:0]};
      res.page_size_code     = SIZE_4K;
      busy_d                 = 1'b0;
      level_d                = LVL_TOP;
    end else begin
      level_d          = level_q + 2'd1;
      res.result_kind  = KIND_READ;
      res.read_address = entry_addr(word_i.entry_word, level_d, va_q) + offset_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      busy_q   <= 1'b0;
      level_q  <= LVL_TOP;
      va_q     <= '0;
    end else begin
      if (cfg_write_enable_i) begin
        offset_q <= cfg_write_data_i;
      end
      if (ctrl_i.advance) begin
        busy_q  <= busy_d;
        level_q <= level_d;
        va_q    <= va_d;
      end
    end
  end

  assign result_o = res;

endmodule

`default_nettype wire

// File: sv/pltw_out_reg.sv
// Result register of the page table walker.
`default_nettype none

module pltw_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pltw_pkg::stage_ctrl_t ctrl_i,
  input  pltw_pkg::out_word_t   result_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output pltw_pkg::out_word_t   result_o
);
  import pltw_pkg::*;

  logic      valid_q;
  out_word_t result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.advance) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire
